>>> src/bstl_pkg.sv
// Package for the binary STL stream parser: constants, item kinds, status codes,
// parse phases and the IEEE single ordered compare used by the bounds tracker.
// No dependencies.
package bstl_pkg;

  localparam int HEADER_BYTES_DEF = 80;
  localparam int RECORD_BYTES_DEF = 50;
  localparam int FLOAT_BYTES      = 48;
  localparam int NUM_BOUNDS       = 6;
  localparam int IN_TDATA_W       = 8;
  localparam int OUT_TDATA_W      = 72;
  localparam int OUT_TUSER_W      = 2;

  typedef enum logic [1:0] {
    KIND_FLOAT  = 2'd0,
    KIND_BOUND  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_MISMATCH = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_COUNT   = 2'd1,
    PH_RECORDS = 2'd2,
    PH_TRAIL   = 2'd3
  } phase_t;

  // What the front end hands to the back end for one accepted byte.
  typedef struct packed {
    logic        word_vld;   // a float word completed
    logic [3:0]  word_idx;
    logic [31:0] tri_idx;
    logic [31:0] word;
    logic        eof;
    status_t     st;
    logic [31:0] count;
  } ev_t;

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  // Ordered a < b; false if either is NaN, signed zeros equal.
  function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
    logic r;
    r = 1'b0;
    if (is_nan(a) || is_nan(b)) r = 1'b0;
    else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) r = 1'b0;
    else if (a[31] != b[31]) r = a[31];
    else if (!a[31]) r = a[30:0] < b[30:0];
    else r = a[30:0] > b[30:0];
    return r;
  endfunction

endpackage

>>> src/binary_stl_stream_parser_bounds.sv
// Binary STL parser with bounding box. One byte per cycle sustained.
// A float word passes the front end's event register, the event queue and the output
// register; on end of file the six bound words and the status follow at one per cycle
// while out_tready is high (after the float word when the last byte also completes one).
// Input stalls only while six or more events wait in the queue.
// rst_n synchronous active low; the block also returns to reset after each file.
module binary_stl_stream_parser_bounds #(
  parameter int HEADER_BYTES = bstl_pkg::HEADER_BYTES_DEF,
  parameter int RECORD_BYTES = bstl_pkg::RECORD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [bstl_pkg::IN_TDATA_W-1:0] in_tdata,   // data_byte
  input  logic       in_tlast,                        // end_of_file
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [bstl_pkg::OUT_TDATA_W-1:0] out_tdata, // word_index, triangle_index, value, status
  output logic [bstl_pkg::OUT_TUSER_W-1:0] out_tuser, // kind
  output logic       out_tlast                        // last_of_run
);
  import bstl_pkg::*;

  localparam int QDEPTH = 8;

  logic in_acc;
  logic fe_vld, q_empty, q_pop, q_wr;
  ev_t  fe_ev, q_ev, split_ev;
  logic split_r;
  logic [$clog2(QDEPTH):0] q_level;

  // Room for two events still in flight plus this one.
  assign in_tready = (q_level <= 4'(QDEPTH - 3));
  assign in_acc    = in_tvalid && in_tready;

  bstl_front #(.HEADER_BYTES(HEADER_BYTES), .RECORD_BYTES(RECORD_BYTES)) u_front (
    .clk, .rst_n,
    .byte_vld(in_acc), .byte_dat(in_tdata), .byte_eof(in_tlast),
    .ev_vld(fe_vld), .ev(fe_ev)
  );

  assign q_wr = fe_vld;

  bstl_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk, .rst_n,
    .wr_en(q_wr), .wr_dat(fe_ev), .rd_en(q_pop),
    .empty(q_empty), .rd_dat(q_ev), .level(q_level)
  );

  // A word and end of file in one entry: word goes first, then entry is reused
  // as a pure end-of-file event.
  logic be_pop;
  always_comb begin
    split_ev = q_ev;
    if (split_r) split_ev.word_vld = 1'b0;
  end
  assign q_pop = be_pop && (!q_ev.word_vld || !q_ev.eof || split_r);

  always_ff @(posedge clk) begin
    if (!rst_n) split_r <= 1'b0;
    else if (be_pop && q_ev.word_vld && q_ev.eof && !split_r) split_r <= 1'b1;
    else if (q_pop) split_r <= 1'b0;
  end

  logic be_pop_raw;
  bstl_back u_back (
    .clk, .rst_n,
    .ev_vld(!q_empty), .ev(split_ev), .ev_pop(be_pop_raw),
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );
  // Back end holds an eof-with-word entry; release it to the split logic.
  assign be_pop = be_pop_raw || (!q_empty && (!out_tvalid || out_tready)
                                 && split_ev.word_vld && split_ev.eof);

  property p_last_is_status;
    @(posedge clk) disable iff (!rst_n)
      (out_tvalid && out_tlast) |-> (out_tuser == KIND_STATUS);
  endproperty
  a_last_is_status: assert property (p_last_is_status) else $error("tlast on non-status");

  property p_no_overflow;
    @(posedge clk) disable iff (!rst_n) q_level <= 4'(QDEPTH);
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("event queue overflow");

endmodule

>>> src/bstl_front.sv
// Front end: byte parser. Tracks header, count and record positions and
// assembles float words. Depends on bstl_pkg.
module bstl_front #(
  parameter int HEADER_BYTES = bstl_pkg::HEADER_BYTES_DEF,
  parameter int RECORD_BYTES = bstl_pkg::RECORD_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_vld,
  input  logic [7:0]    byte_dat,
  input  logic          byte_eof,
  output logic          ev_vld,
  output bstl_pkg::ev_t ev
);
  import bstl_pkg::*;

  localparam logic [6:0] HDR_LAST = 7'(HEADER_BYTES - 1);
  localparam logic [5:0] REC_LAST = 6'(RECORD_BYTES - 1);
  localparam logic [5:0] FLT_END  = 6'(FLOAT_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [6:0]  hpos_r, hpos_nxt;
  logic [5:0]  rpos_r, rpos_nxt;
  logic [23:0] asm_r, asm_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] done_r, done_nxt;
  logic [31:0] full_w;
  ev_t         ev_nxt;

  assign full_w = {byte_dat, asm_r};

  always_comb begin
    phase_nxt = phase_r;
    hpos_nxt  = hpos_r;
    rpos_nxt  = rpos_r;
    asm_nxt   = asm_r;
    count_nxt = count_r;
    done_nxt  = done_r;
    ev_nxt    = '0;
    unique case (phase_r)
      PH_HEADER: begin
        hpos_nxt = hpos_r + 7'd1;
        if (hpos_r >= HDR_LAST) begin
          phase_nxt = PH_COUNT;
          rpos_nxt  = '0;
        end
      end
      PH_COUNT: begin
        if (rpos_r[1:0] != 2'd3) begin
          asm_nxt[8*rpos_r[1:0] +: 8] = byte_dat;
          rpos_nxt = rpos_r + 6'd1;
        end else begin
          count_nxt = full_w;
          asm_nxt   = '0;
          rpos_nxt  = '0;
          phase_nxt = (full_w != 32'd0) ? PH_RECORDS : PH_TRAIL;
        end
      end
      PH_RECORDS: begin
        if (rpos_r < FLT_END) begin
          if (rpos_r[1:0] != 2'd3) begin
            asm_nxt[8*rpos_r[1:0] +: 8] = byte_dat;
          end else begin
            asm_nxt         = '0;
            ev_nxt.word_vld = 1'b1;
            ev_nxt.word_idx = rpos_r[5:2];
            ev_nxt.tri_idx  = done_r;
            ev_nxt.word     = full_w;
          end
        end
        rpos_nxt = rpos_r + 6'd1;
        if (rpos_r >= REC_LAST) begin
          rpos_nxt = '0;
          done_nxt = done_r + 32'd1;
          if (done_nxt >= count_r) phase_nxt = PH_TRAIL;
        end
      end
      PH_TRAIL: ;
      default: ;
    endcase
    ev_nxt.eof   = byte_eof;
    ev_nxt.count = count_nxt;
    if (phase_nxt == PH_HEADER || phase_nxt == PH_COUNT) ev_nxt.st = ST_SHORT;
    else if (done_nxt < count_nxt) ev_nxt.st = ST_MISMATCH;
    else ev_nxt.st = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_vld && byte_eof)) begin
      phase_r <= PH_HEADER;
      hpos_r  <= '0;
      rpos_r  <= '0;
      asm_r   <= '0;
      count_r <= '0;
      done_r  <= '0;
    end else if (byte_vld) begin
      phase_r <= phase_nxt;
      hpos_r  <= hpos_nxt;
      rpos_r  <= rpos_nxt;
      asm_r   <= asm_nxt;
      count_r <= count_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ev_vld <= 1'b0;
    else ev_vld <= byte_vld && (ev_nxt.word_vld || byte_eof);
  end

  always_ff @(posedge clk) begin
    if (byte_vld) ev <= ev_nxt;
  end

endmodule

>>> src/bstl_fifo.sv
// Short event queue between parser and emitter.
// Depends on bstl_pkg.
module bstl_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  bstl_pkg::ev_t wr_dat,
  input  logic          rd_en,
  output logic          empty,
  output bstl_pkg::ev_t rd_dat,
  output logic [$clog2(DEPTH):0] level
);
  import bstl_pkg::*;

  localparam int AW = $clog2(DEPTH);

  ev_t           mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign empty  = (cnt_r == '0);
  assign rd_dat = mem_r[rp_r];
  assign level  = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_dat;
  end

endmodule

>>> src/bstl_back.sv
// Back end: emits float words, tracks bounds, and on end of file emits six
// bound words and the status word. Depends on bstl_pkg.
module bstl_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ev_vld,
  input  bstl_pkg::ev_t ev,
  output logic          ev_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [bstl_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [bstl_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic          out_tlast
);
  import bstl_pkg::*;

  logic [31:0] bnd_r [NUM_BOUNDS];
  logic        seeded_r;
  logic [2:0]  sub_r;      // 0 float / first bound, then bounds, 6 = status
  logic        busy_eof;
  logic        load;
  logic        fire;
  logic [2:0]  axis2;
  logic [31:0] bval;
  kind_t       kind_c;
  logic [3:0]  widx_c;
  logic [31:0] tri_c, val_c;
  status_t     st_c;
  logic        last_c;

  assign busy_eof = ev_vld && ev.eof && !ev.word_vld;
  assign load     = !out_tvalid || out_tready;
  assign fire     = ev_vld && load;

  // Float word goes out first; an end of file on the same byte follows it.
  always_comb begin
    kind_c = KIND_FLOAT;
    widx_c = ev.word_idx;
    tri_c  = ev.tri_idx;
    val_c  = ev.word;
    st_c   = ST_OK;
    last_c = 1'b0;
    bval   = ((ev.st == ST_OK) && (ev.count != 32'd0)) ? bnd_r[sub_r] : 32'd0;
    if (busy_eof) begin
      if (sub_r == 3'd6) begin
        kind_c = KIND_STATUS;
        widx_c = '0;
        tri_c  = ev.count;
        val_c  = '0;
        st_c   = ev.st;
        last_c = 1'b1;
      end else begin
        kind_c = KIND_BOUND;
        widx_c = {1'b0, sub_r};
        tri_c  = '0;
        val_c  = bval;
      end
    end
  end

  assign ev_pop = fire && (busy_eof ? (sub_r == 3'd6) : !ev.eof);

  always_ff @(posedge clk) begin
    if (!rst_n) sub_r <= '0;
    else if (fire && busy_eof) sub_r <= (sub_r == 3'd6) ? 3'd0 : sub_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (load) out_tvalid <= ev_vld;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_tdata <= {2'b00, st_c, val_c, tri_c, widx_c};
      out_tuser <= kind_c;
      out_tlast <= last_c;
    end
  end

  // Vertex word to its min/max pair: x words 0/1, y words 2/3, z words 4/5.
  always_comb begin
    case (ev.word_idx) inside
      4'd4, 4'd7, 4'd10: axis2 = 3'd2;
      4'd5, 4'd8, 4'd11: axis2 = 3'd4;
      default:           axis2 = 3'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r <= 1'b0;
      for (int i = 0; i < NUM_BOUNDS; i++) bnd_r[i] <= '0;
    end else if (fire && busy_eof && sub_r == 3'd6) begin
      seeded_r <= 1'b0;
      for (int i = 0; i < NUM_BOUNDS; i++) bnd_r[i] <= '0;
    end else if (fire && ev.word_vld && ev.word_idx >= 4'd3) begin
      if (!seeded_r) begin
        bnd_r[axis2]        <= ev.word;
        bnd_r[axis2 + 3'd1] <= ev.word;
        if (ev.word_idx == 4'd5) seeded_r <= 1'b1;
      end else begin
        if (flt_lt(ev.word, bnd_r[axis2]))        bnd_r[axis2]        <= ev.word;
        if (flt_lt(bnd_r[axis2 + 3'd1], ev.word)) bnd_r[axis2 + 3'd1] <= ev.word;
      end
    end
  end

endmodule

>>> dv/bstl_checker.sv
// Checker for the binary STL parser: watches both stream channels, predicts the
// float, bound and status words for each accepted byte, and compares them in order.
// Depends on bstl_pkg for kind, status and phase codes.
`timescale 1ns / 1ps
module bstl_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          fails,
  output int          pending,
  output int          files_seen,
  output int          words_seen
);
  import bstl_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [3:0]  widx;
    logic [31:0] tri_no;
    logic [31:0] val;
    status_t     st;
    logic        last;
  } stl_word_t;

  stl_word_t   expected_words[$];

  // parser state mirror
  phase_t      ph;
  logic [6:0]  hdr_pos;
  logic [31:0] tri_count;
  logic [31:0] asm_word;
  logic [5:0]  rec_pos;
  logic [31:0] recs_done;
  logic [31:0] bbox [6];
  logic        seeded;

  // IEEE ordered a < b: NaN never compares, signed zeros are equal
  function automatic logic fp_less(input logic [31:0] a, input logic [31:0] b);
    logic a_nan, b_nan;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
    if (a_nan || b_nan) return 1'b0;
    if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
    if (a[31] != b[31]) return a[31];
    if (!a[31]) return a[30:0] < b[30:0];
    return a[30:0] > b[30:0];
  endfunction

  task automatic clear_parser();
    ph = PH_HEADER;
    hdr_pos = '0;
    tri_count = '0;
    asm_word = '0;
    rec_pos = '0;
    recs_done = '0;
    seeded = 1'b0;
    for (int i = 0; i < 6; i++) bbox[i] = '0;
  endtask

  task automatic add_word(kind_t k, logic [3:0] wi, logic [31:0] t, logic [31:0] v,
                          status_t s, logic l);
    stl_word_t w;
    w.kind = k; w.widx = wi; w.tri_no = t; w.val = v; w.st = s; w.last = l;
    expected_words.push_back(w);
  endtask

  task automatic track_vertex(logic [3:0] idx, logic [31:0] w);
    int a;
    a = ((idx - 3) % 3) * 2;
    if (!seeded) begin
      bbox[a] = w;
      bbox[a+1] = w;
      if (idx == 5) seeded = 1'b1;
    end else begin
      if (fp_less(w, bbox[a])) bbox[a] = w;
      if (fp_less(bbox[a+1], w)) bbox[a+1] = w;
    end
  endtask

  task automatic parse_byte(logic [7:0] b, logic eof);
    logic [31:0] w;
    logic [3:0]  idx;
    status_t     st;
    case (ph)
      PH_HEADER: begin
        hdr_pos = hdr_pos + 1;
        if (hdr_pos >= HEADER_BYTES_DEF) begin
          ph = PH_COUNT;
          rec_pos = '0;
        end
      end
      PH_COUNT: begin
        if (rec_pos[1:0] != 2'd3) begin
          asm_word = asm_word | (32'(b) << (8 * rec_pos[1:0]));
          rec_pos = rec_pos + 1;
        end else begin
          tri_count = asm_word | (32'(b) << 24);
          asm_word = '0;
          rec_pos = '0;
          ph = (tri_count != 0) ? PH_RECORDS : PH_TRAIL;
        end
      end
      PH_RECORDS: begin
        if (rec_pos < FLOAT_BYTES) begin
          if (rec_pos[1:0] != 2'd3) begin
            asm_word = asm_word | (32'(b) << (8 * rec_pos[1:0]));
          end else begin
            w = asm_word | (32'(b) << 24);
            idx = rec_pos[5:2];
            asm_word = '0;
            add_word(KIND_FLOAT, idx, recs_done, w, ST_OK, 1'b0);
            if (idx >= 3) track_vertex(idx, w);
          end
        end
        rec_pos = rec_pos + 1;
        if (rec_pos >= RECORD_BYTES_DEF) begin
          rec_pos = '0;
          recs_done = recs_done + 1;
          if (recs_done >= tri_count) ph = PH_TRAIL;
        end
      end
      default: ;
    endcase
    if (eof) begin
      if (ph == PH_HEADER || ph == PH_COUNT) st = ST_SHORT;
      else if (recs_done < tri_count) st = ST_MISMATCH;
      else st = ST_OK;
      for (int i = 0; i < 6; i++)
        add_word(KIND_BOUND, 4'(i), '0,
                 (st == ST_OK && tri_count != 0) ? bbox[i] : 32'd0, ST_OK, 1'b0);
      add_word(KIND_STATUS, 4'd0, tri_count, '0, st, 1'b1);
      clear_parser();
    end
  endtask

  always @(posedge clk) begin
    stl_word_t e;
    logic [1:0] a_kind;
    logic [3:0] a_widx;
    logic [31:0] a_tri, a_val;
    logic [1:0] a_st;
    if (!rst_n) begin
      clear_parser();
      expected_words.delete();
    end else begin
      if (in_tvalid && in_tready) parse_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        a_kind = out_tuser[1:0];
        a_widx = out_tdata[3:0];
        a_tri  = out_tdata[35:4];
        a_val  = out_tdata[67:36];
        a_st   = out_tdata[69:68];
        words_seen++;
        if (out_tlast) files_seen++;
        if (expected_words.size() == 0) begin
          fails++;
          $display("%0t: unexpected word kind=%0d idx=%0d tri=%h val=%h st=%0d last=%b",
                   $time, a_kind, a_widx, a_tri, a_val, a_st, out_tlast);
        end else begin
          e = expected_words.pop_front();
          if (a_kind !== e.kind || a_widx !== e.widx || a_tri !== e.tri_no ||
              a_val !== e.val || a_st !== e.st || out_tlast !== e.last) begin
            fails++;
            $display("%0t: expected kind=%0d idx=%0d tri=%h val=%h st=%0d last=%b",
                     $time, e.kind, e.widx, e.tri_no, e.val, e.st, e.last);
            $display("%0t:   actual kind=%0d idx=%0d tri=%h val=%h st=%0d last=%b",
                     $time, a_kind, a_widx, a_tri, a_val, a_st, out_tlast);
          end
        end
      end
    end
    pending <= expected_words.size();
  end

  initial begin
    fails = 0;
    pending = 0;
    files_seen = 0;
    words_seen = 0;
    clear_parser();
  end
endmodule

>>> dv/tb.sv
// Top of the binary STL parser testbench: clock, reset, byte stimulus built as
// whole and damaged STL files, output back-pressure and the verdict.
// Depends on bstl_pkg, bstl_checker and binary_stl_stream_parser_bounds.
`timescale 1ns / 1ps
module tb;
  import bstl_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  int          fails, pending, files_seen, words_seen;
  int          bytes_sent;
  logic        quiet;
  logic [7:0]  file_bytes[$];

  binary_stl_stream_parser_bounds dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  bstl_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .fails(fails), .pending(pending), .files_seen(files_seen), .words_seen(words_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mixes awkward floats: zeros of both signs, NaNs, infinities, tiny and huge values
  function automatic logic [31:0] pick_float();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: r = {r[31], 31'd0};
      1: r = {r[31], 8'hFF, r[22:1], 1'b1};
      2: r = {r[31], 8'hFF, 23'd0};
      3: r = {r[31], 8'h00, r[22:0]};
      4: r = {r[31], 8'h7F, 19'd0, r[3:0]};
      default: ;
    endcase
    return r;
  endfunction

  task automatic put_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
  endtask

  // header, count, nrec records of the given first-vertex style
  task automatic build_file(logic [31:0] count, int nrec, logic [31:0] v0);
    file_bytes.delete();
    for (int i = 0; i < HEADER_BYTES_DEF; i++) file_bytes.push_back(8'($urandom));
    put_word(count);
    for (int r = 0; r < nrec; r++) begin
      for (int w = 0; w < 12; w++)
        put_word((r == 0 && w >= 3 && w < 6 && v0 != 0) ? v0 : pick_float());
      file_bytes.push_back(8'($urandom));
      file_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= file_bytes[i];
      in_tlast  <= (i == file_bytes.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      bytes_sent++;
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
  endtask

  // receiver back-pressure
  initial begin
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    quiet = 1'b0;
    bytes_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // end of file inside the header, then inside the count
    build_file(32'd1, 0, 32'd0);
    file_bytes = file_bytes[0:2];
    send_file();
    build_file(32'd1, 0, 32'd0);
    file_bytes = file_bytes[0:HEADER_BYTES_DEF+1];
    send_file();
    // zero triangles with a few trailing bytes
    build_file(32'd0, 1, 32'd0);
    file_bytes = file_bytes[0:HEADER_BYTES_DEF+7];
    send_file();
    // one whole record with a NaN first vertex
    build_file(32'd1, 1, 32'h7FC0_0001);
    send_file();
    // no idling from here: huge declared count, negative zero first, cut mid record
    quiet = 1'b1;
    build_file(32'hFFFF_FFFE, 1, 32'h8000_0000);
    file_bytes = file_bytes[0:HEADER_BYTES_DEF+23];
    send_file();

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes as whole, damaged and truncated STL files;", bytes_sent);
    $display("checked %0d output words across %0d status words.", words_seen, files_seen);
    if (fails == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

>>> sim.f
src/bstl_pkg.sv
src/bstl_front.sv
src/bstl_fifo.sv
src/bstl_back.sv
src/binary_stl_stream_parser_bounds.sv
dv/bstl_checker.sv
dv/tb.sv
